>>> design/b2da_pkg.sv
// ----------------------------------------------------------------------------
// b2da_pkg: shared definitions for the binary to decimal ASCII converter
// Widths, constants and the double-dabble step used by the pipeline stages.
// ----------------------------------------------------------------------------
package b2da_pkg;

  localparam int BIN_W           = 32;
  localparam int DIGIT_W         = 6;
  localparam int NIB_W           = 4;
  localparam int U32_DIGITS      = 10;
  localparam int BCD_W           = U32_DIGITS * NIB_W;
  localparam int DEF_MAX_DIGITS  = 10;
  localparam int STEPS_PER_STAGE = 4;
  localparam int NUM_STAGES      = BIN_W / STEPS_PER_STAGE;
  localparam int TOP_W           = 4;

  localparam logic [DIGIT_W-1:0] ASCII_ZERO   = 6'd48;
  localparam logic [NIB_W-1:0]   ADD3_LIMIT   = 4'd5;
  localparam logic [NIB_W-1:0]   ADD3_VALUE   = 4'd3;

  typedef struct packed {
    logic [BCD_W-1:0] bcd;
    logic [BIN_W-1:0] bin;
  } dab_t;

  // One shift-and-add-3 step: correct every BCD nibble, then shift the
  // next binary bit into the BCD field.
  function automatic dab_t dab_step(input dab_t s);
    dab_t r;
    logic [NIB_W-1:0] nib;
    r = s;
    for (int i = 0; i < U32_DIGITS; i++) begin
      nib = s.bcd[i*NIB_W +: NIB_W];
      if (nib >= ADD3_LIMIT) begin
        r.bcd[i*NIB_W +: NIB_W] = nib + ADD3_VALUE;
      end
    end
    r = dab_t'({r.bcd, r.bin} << 1);
    return r;
  endfunction

endpackage

>>> design/b2da_value_if.sv
// ----------------------------------------------------------------------------
// b2da_value_if: channel carrying one binary value per beat
// Valid/ready handshake with a 32-bit unsigned payload.
// ----------------------------------------------------------------------------
interface b2da_value_if;
  import b2da_pkg::*;

  logic             valid;
  logic             ready;
  logic [BIN_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

>>> design/b2da_digit_if.sv
// ----------------------------------------------------------------------------
// b2da_digit_if: channel carrying one ASCII digit per beat
// Valid/ready handshake with the digit code and an end-of-run flag.
// ----------------------------------------------------------------------------
interface b2da_digit_if;
  import b2da_pkg::*;

  logic               valid;
  logic               ready;
  logic [DIGIT_W-1:0] ascii_digit;
  logic               last;

  modport source (output valid, output ascii_digit, output last, input ready);
  modport sink   (input valid, input ascii_digit, input last, output ready);
endinterface

>>> design/b2da_dabble_stage.sv
// ----------------------------------------------------------------------------
// b2da_dabble_stage: one register stage of the double-dabble pipeline
// Applies a fixed number of shift-and-add-3 steps and registers the result.
// ----------------------------------------------------------------------------
module b2da_dabble_stage (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  b2da_pkg::dab_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output b2da_pkg::dab_t out_data
);
  import b2da_pkg::*;

  logic valid;
  dab_t data;
  dab_t data_next;

  always_comb begin
    data_next = in_data;
    for (int s = 0; s < STEPS_PER_STAGE; s++) begin
      data_next = dab_step(data_next);
    end
  end

  // The stage takes a new beat whenever it is empty or its content leaves.
  assign in_ready = !valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data <= data_next;
    end
  end

  assign out_valid = valid;
  assign out_data  = data;

endmodule

>>> design/b2da_serializer.sv
// ----------------------------------------------------------------------------
// b2da_serializer: digit counter and character output
// Finds the significant digit count and sends one ASCII digit per beat.
// ----------------------------------------------------------------------------
module b2da_serializer #(
  parameter int MAX_DIGITS = b2da_pkg::DEF_MAX_DIGITS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [b2da_pkg::BCD_W-1:0] in_bcd,
  b2da_digit_if.source              digit
);
  import b2da_pkg::*;

  localparam int LIM   = (MAX_DIGITS < 1) ? 1 :
                         ((MAX_DIGITS > U32_DIGITS) ? U32_DIGITS : MAX_DIGITS);
  localparam int IDX_W = (LIM > 1) ? $clog2(LIM) : 1;
  localparam logic [TOP_W-1:0] TOP_MAX = TOP_W'(LIM - 1);

  logic                 busy;
  logic [IDX_W-1:0]     idx;
  logic [IDX_W-1:0]     idx_next;
  logic [NIB_W-1:0]     dig [LIM];
  logic [TOP_W-1:0]     top;
  logic                 load;
  logic                 send;
  logic                 at_last;

  // Position of the most significant nonzero digit; zero gives position 0.
  always_comb begin
    top = '0;
    for (int i = 0; i < U32_DIGITS; i++) begin
      if (in_bcd[i*NIB_W +: NIB_W] != '0) begin
        top = TOP_W'(i);
      end
    end
  end

  // Digits above the register size are dropped.
  assign idx_next = (top > TOP_MAX) ? IDX_W'(TOP_MAX) : IDX_W'(top);

  assign at_last  = (idx == '0);
  assign send     = digit.valid && digit.ready;
  assign in_ready = !busy || (digit.ready && at_last);
  assign load     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (load) begin
      busy <= 1'b1;
    end else if (send && at_last) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      idx <= idx_next;
      for (int i = 0; i < LIM; i++) begin
        dig[i] <= in_bcd[i*NIB_W +: NIB_W];
      end
    end else if (send) begin
      idx <= idx - IDX_W'(1);
    end
  end

  assign digit.valid       = busy;
  assign digit.ascii_digit = ASCII_ZERO | {{(DIGIT_W-NIB_W){1'b0}}, dig[idx]};
  assign digit.last        = at_last;

endmodule

>>> design/binary_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii: unsigned 32-bit binary to decimal ASCII digits
// Double-dabble pipeline followed by a digit serializer.
// ----------------------------------------------------------------------------
// Each beat on the number channel carries an unsigned 32-bit value; the
// block answers with its decimal digits as ASCII codes '0' to '9' on the
// digit channel, most significant first, leading zeros suppressed, one
// digit per beat, with last set on the units digit. Zero gives a single
// '0'. Only the MAX_DIGITS least significant digits are sent when the
// number is longer. The conversion runs through eight register stages of
// four shift-and-add-3 steps each, and a new value may enter the pipeline
// in every cycle unless the digit output holds back the stages. The
// serializer sends one digit per cycle while the digit channel is ready,
// and takes the next value as the units digit of the current one leaves,
// so the single digit output sets the sustained rate, while later values
// wait in the pipeline stages. No state is kept between values.
module binary_to_decimal_ascii #(
  parameter int MAX_DIGITS = b2da_pkg::DEF_MAX_DIGITS
) (
  input  logic         clk,
  input  logic         rst,
  b2da_value_if.sink   number,
  b2da_digit_if.source digit
);
  import b2da_pkg::*;

  // Handshake and payload between consecutive stages; index 0 is the input.
  logic stg_valid [NUM_STAGES+1];
  logic stg_ready [NUM_STAGES+1];
  dab_t stg_data  [NUM_STAGES+1];

  assign stg_valid[0] = number.valid;
  assign number.ready = stg_ready[0];
  assign stg_data[0]  = '{bcd: '0, bin: number.value};

  for (genvar g = 0; g < NUM_STAGES; g++) begin : g_stage
    b2da_dabble_stage u_stage (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (stg_valid[g]),
      .in_ready  (stg_ready[g]),
      .in_data   (stg_data[g]),
      .out_valid (stg_valid[g+1]),
      .out_ready (stg_ready[g+1]),
      .out_data  (stg_data[g+1])
    );
  end

  // After all shifts the BCD field holds the full decimal value.
  b2da_serializer #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_serializer (
    .clk      (clk),
    .rst      (rst),
    .in_valid (stg_valid[NUM_STAGES]),
    .in_ready (stg_ready[NUM_STAGES]),
    .in_bcd   (stg_data[NUM_STAGES].bcd),
    .digit    (digit)
  );

endmodule

>>> tb/sv/binary_to_decimal_ascii_tb.sv
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_tb: self-checking bench for the decimal converter
// Feeds 32-bit values, predicts each digit run and checks every digit beat,
// under changing idle and stall patterns and one long output hold-off.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii_tb;
  import b2da_pkg::*;

  // The digit count that the block is built with. A 32-bit value never has
  // more than ten digits, so the default never truncates a run.
  localparam int DUT_MAX_DIGITS = DEF_MAX_DIGITS;

  // Length of the long receiver hold-off, in cycles. It is far longer than
  // the pipeline depth, so the stages fill and the number channel backs up.
  localparam int HOLD_CYCLES = 80;

  // Cycles to keep watching after the last expected digit, so that a stray
  // extra digit still in the pipeline gets caught.
  localparam int DRAIN_CYCLES = NUM_STAGES + U32_DIGITS + 12;

  localparam int MAX_REPORTS = 10;

  // How the two sides idle while an item is in flight.
  typedef enum logic [1:0] {
    PH_STEADY,      // no gaps, no stalls
    PH_SRC_GAPS,    // sender idles 46 percent of the time
    PH_SINK_STALLS, // receiver stalls 46 percent of the time
    PH_BOTH         // both idle, 17 percent of the time each
  } idle_mode_t;

  typedef struct {
    logic [BIN_W-1:0] value;
    idle_mode_t       mode;
    bit               hold;  // starts the long receiver hold-off
  } value_item_t;

  typedef struct {
    logic [DIGIT_W-1:0] code;
    logic               last;
  } digit_beat_t;

  logic clk;
  logic rst;

  b2da_value_if number_ch ();
  b2da_digit_if digit_ch ();

  binary_to_decimal_ascii #(
    .MAX_DIGITS(DUT_MAX_DIGITS)
  ) dut (
    .clk   (clk),
    .rst   (rst),
    .number(number_ch.sink),
    .digit (digit_ch.source)
  );

  // Values still to be offered, and the digit beats the block owes us.
  value_item_t pending_values[$];
  digit_beat_t expected_digits[$];

  idle_mode_t cur_mode;
  logic       hold_kick;
  int         hold_left;

  int values_queued;
  int values_taken;
  int digits_checked;
  int mismatches;
  bit run_len_seen[U32_DIGITS+1];

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // Percentage of cycles in which one side sits idle for a given mode.
  function automatic int idle_pct(input idle_mode_t mode, input bit sink_side);
    case (mode)
      PH_SRC_GAPS:    return sink_side ? 0 : 46;
      PH_SINK_STALLS: return sink_side ? 46 : 0;
      PH_BOTH:        return 17;
      default:        return 0;
    endcase
  endfunction

  // Predicts the digit run for one value: peel off decimal digits from the
  // units end, keep at most the configured number of them, then queue them
  // most significant first with the end flag on the units digit.
  function automatic void queue_decimal_digits(input logic [BIN_W-1:0] value);
    logic [NIB_W-1:0] rev_digits[U32_DIGITS];
    logic [BIN_W-1:0] rest;
    digit_beat_t      beat;
    int               count;
    int               keep;
    rest  = value;
    count = 0;
    do begin
      rev_digits[count] = NIB_W'(rest % 10);
      rest              = rest / 10;
      count++;
    end while (rest != 0 && count < U32_DIGITS);
    keep = DUT_MAX_DIGITS;
    if (keep < 1) begin
      keep = 1;
    end
    if (count > keep) begin
      count = keep;
    end
    for (int k = 0; k < count; k++) begin
      beat.code = ASCII_ZERO + DIGIT_W'(rev_digits[count - 1 - k]);
      beat.last = (k == count - 1);
      expected_digits.push_back(beat);
    end
    run_len_seen[count] = 1'b1;
  endfunction

  // A value whose digit count is picked first, so short and long runs show
  // up equally often; now and then a plain 32-bit random word instead.
  function automatic logic [BIN_W-1:0] random_value();
    longint unsigned lo;
    longint unsigned hi;
    int              ndig;
    if ($urandom_range(7) == 0) begin
      return $urandom;
    end
    ndig = $urandom_range(U32_DIGITS, 1);
    lo   = 1;
    for (int i = 1; i < ndig; i++) begin
      lo = lo * 10;
    end
    hi = lo * 10 - 1;
    if (ndig == 1) begin
      lo = 0;
    end
    if (hi > 64'hFFFF_FFFF) begin
      hi = 64'hFFFF_FFFF;
    end
    return $urandom_range(BIN_W'(hi), BIN_W'(lo));
  endfunction

  task automatic add_value(input logic [BIN_W-1:0] value, input idle_mode_t mode,
                           input bit hold);
    value_item_t item;
    item.value = value;
    item.mode  = mode;
    item.hold  = hold;
    pending_values.push_back(item);
    values_queued++;
  endtask

  task automatic note_mismatch(input string what, input bit have_want,
                               input digit_beat_t want);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      if (have_want) begin
        $display("%s: expected digit %0d last %0d, got digit %0d last %0d",
                 what, want.code, want.last, digit_ch.ascii_digit, digit_ch.last);
      end else begin
        $display("%s: got digit %0d last %0d", what, digit_ch.ascii_digit,
                 digit_ch.last);
      end
    end
  endtask

  // Sender. When the number channel slot is free (nothing offered, or the
  // offered beat is taken at this edge) it either offers the next pending
  // value or idles, depending on the mode of that value. The receiver
  // follows the mode of the value most recently offered.
  always @(posedge clk) begin
    value_item_t nxt;
    bit          slot_free;
    bit          take;
    if (rst) begin
      number_ch.valid <= 1'b0;
      number_ch.value <= '0;
      hold_kick       <= 1'b0;
      cur_mode        <= PH_STEADY;
    end else begin
      slot_free = !number_ch.valid || number_ch.ready;
      take      = 1'b0;
      if (slot_free && pending_values.size() != 0) begin
        if ($urandom_range(99) >= idle_pct(pending_values[0].mode, 1'b0)) begin
          take = 1'b1;
          nxt  = pending_values.pop_front();
        end
      end
      if (slot_free) begin
        number_ch.valid <= take;
      end
      if (take) begin
        number_ch.value <= nxt.value;
        cur_mode        <= nxt.mode;
      end
      hold_kick <= take && nxt.hold;
    end
  end

  // The long hold-off runs in a counter of its own; the receiver simply
  // keeps ready low while it is nonzero.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_kick) begin
      hold_left <= HOLD_CYCLES;
    end
  end

  // Receiver and checker. The output beat of this edge is checked against
  // the oldest expectation before the input beat of the same edge adds its
  // own digits, so an output can never be matched against its own input.
  always @(posedge clk) begin
    digit_beat_t want;
    if (rst) begin
      digit_ch.ready <= 1'b0;
    end else begin
      digit_ch.ready <= (hold_left == 0) &&
                        ($urandom_range(99) >= idle_pct(cur_mode, 1'b1));
      if (digit_ch.valid && digit_ch.ready) begin
        digits_checked++;
        if (expected_digits.size() == 0) begin
          note_mismatch("digit beat with nothing expected", 1'b0, want);
        end else begin
          want = expected_digits.pop_front();
          if (digit_ch.ascii_digit !== want.code || digit_ch.last !== want.last) begin
            note_mismatch("digit beat mismatch", 1'b1, want);
          end
        end
      end
      if (number_ch.valid && number_ch.ready) begin
        queue_decimal_digits(number_ch.value);
        values_taken++;
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    int lengths_hit;
    number_ch.valid = 1'b0;
    number_ch.value = '0;
    digit_ch.ready  = 1'b0;
    rst             = 1'b1;
    values_queued   = 0;
    values_taken    = 0;
    digits_checked  = 0;
    mismatches      = 0;

    // Directed values: zero (the one-character run), the single-digit and
    // some power-of-ten boundaries where the run length changes, the largest
    // 32-bit values with their full ten digits, and alternating bit
    // patterns so that every input bit is seen both low and high.
    add_value(32'd0, PH_STEADY, 1'b0);
    add_value(32'd1, PH_STEADY, 1'b0);
    add_value(32'd9, PH_STEADY, 1'b0);
    add_value(32'd10, PH_STEADY, 1'b0);
    add_value(32'd99, PH_STEADY, 1'b0);
    add_value(32'd100, PH_STEADY, 1'b0);
    add_value(32'd9999, PH_STEADY, 1'b0);
    add_value(32'd100000, PH_STEADY, 1'b0);
    add_value(32'd9999999, PH_STEADY, 1'b0);
    add_value(32'd99999999, PH_STEADY, 1'b0);
    add_value(32'd999999999, PH_STEADY, 1'b0);
    add_value(32'd1000000000, PH_STEADY, 1'b0);
    add_value(32'd1234567890, PH_STEADY, 1'b0);
    add_value(32'd987654321, PH_STEADY, 1'b0);
    add_value(32'h7FFF_FFFF, PH_STEADY, 1'b0);
    add_value(32'h8000_0000, PH_STEADY, 1'b0);
    add_value(32'h5555_5555, PH_STEADY, 1'b0);
    add_value(32'hAAAA_AAAA, PH_STEADY, 1'b0);
    add_value(32'hFFFF_FFFE, PH_STEADY, 1'b0);
    add_value(32'hFFFF_FFFF, PH_STEADY, 1'b0);

    // Back-pressure burst: the first value of the burst starts the long
    // hold-off, and the sender keeps offering without gaps behind it.
    add_value(32'hFFFF_FFFF, PH_STEADY, 1'b1);
    for (int i = 0; i < 14; i++) begin
      add_value(random_value(), PH_STEADY, 1'b0);
    end

    // Random values, one stretch per idle pattern.
    for (int m = 0; m < 4; m++) begin
      for (int i = 0; i < 34; i++) begin
        add_value(random_value(), idle_mode_t'(m), 1'b0);
      end
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (values_taken < values_queued || expected_digits.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    lengths_hit = 0;
    for (int n = 1; n <= U32_DIGITS; n++) begin
      lengths_hit += run_len_seen[n];
    end
    $display("Converted %0d values into %0d digit beats, with %0d of the %0d run lengths,",
             values_taken, digits_checked, lengths_hit, U32_DIGITS);
    $display("under gaps, stalls, and one %0d-cycle output hold-off; %0d mismatches.",
             HOLD_CYCLES, mismatches);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog: a hang anywhere (lost digit, stuck handshake) ends the run here.
  initial begin
    #2_000_000;
    $display("Timed out with %0d values taken and %0d digits still expected.",
             values_taken, expected_digits.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule
